### hw/rtl/multichannel_triac_phase_dimmer_assert.svh
// assertion macros for the dimmer, sampled on clk and held off during reset
`ifndef MULTICHANNEL_TRIAC_PHASE_DIMMER_ASSERT_SVH
`define MULTICHANNEL_TRIAC_PHASE_DIMMER_ASSERT_SVH

// condition that must hold at every edge
`define MTPD_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("dimmer invariant violated");

// condition that must hold whenever the antecedent holds
`define MTPD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dimmer implication violated");

`endif

### hw/rtl/mtpd_pkg.sv
package mtpd_pkg;

    localparam int CHANNELS   = 12;
    localparam int FULL_SCALE = 128;

    // wide enough to compare channel numbers and counts up to 63
    localparam int CNT_W = 6;

    localparam int DELAY_W = 8;
    localparam int STEP_W  = 8;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ZERO = 2'd1,
        REQ_SET  = 2'd2
    } req_t;

    localparam logic CFG_ACTIVE    = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] channel;
        logic [7:0] brightness;
    } item_t;

    typedef struct packed {
        logic [3:0] active_channels;
        logic [7:0] off_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CHANNELS-1:0] gate;
        logic [CHANNELS-1:0] armed;
        logic [CHANNELS-1:0] gate_next;
    } status_t;

    function automatic logic [DELAY_W-1:0] bright_to_delay(
        input logic [7:0] bri,
        input logic [7:0] thr
    );
        logic [7:0] floor_lvl;
        logic [7:0] lvl;
        floor_lvl = (thr > 8'(FULL_SCALE)) ? 8'(FULL_SCALE) : thr;
        lvl       = (bri < floor_lvl) ? floor_lvl : bri;
        if (bri > 8'(FULL_SCALE))
        begin
            return '0;
        end
        return DELAY_W'(8'(FULL_SCALE) - lvl);
    endfunction

endpackage

### hw/rtl/mtpd_cfg.sv
module mtpd_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [7:0]    cfg_data,
    output mtpd_pkg::cfg_t cfg
);

    logic [3:0] active_reg;
    logic [7:0] thresh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 4'd12;
            thresh_reg <= 8'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mtpd_pkg::CFG_ACTIVE:    active_reg <= cfg_data[3:0];
                mtpd_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data;
                default:                 thresh_reg <= thresh_reg;
            endcase
        end
    end

    assign cfg.active_channels = active_reg;
    assign cfg.off_threshold   = thresh_reg;

endmodule

### hw/rtl/mtpd_core.sv
module mtpd_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  mtpd_pkg::item_t   item,
    input  mtpd_pkg::cfg_t    cfg,
    output mtpd_pkg::status_t status
);

    localparam int N = mtpd_pkg::CHANNELS;

    logic [mtpd_pkg::DELAY_W-1:0] delay_reg [N];
    logic [mtpd_pkg::DELAY_W-1:0] delay_next [N];
    logic [mtpd_pkg::STEP_W-1:0]  step_reg [N];
    logic [mtpd_pkg::STEP_W-1:0]  step_next [N];
    logic [N-1:0]                 armed_reg;
    logic [N-1:0]                 armed_next;
    logic [N-1:0]                 gate_reg;
    logic [N-1:0]                 gate_next;

    logic [mtpd_pkg::CNT_W-1:0]   drive_n;
    logic [mtpd_pkg::CNT_W-1:0]   act_ext;
    logic [mtpd_pkg::DELAY_W-1:0] new_delay;

    assign act_ext   = mtpd_pkg::CNT_W'(cfg.active_channels);
    assign drive_n   = (act_ext > mtpd_pkg::CNT_W'(N)) ? mtpd_pkg::CNT_W'(N) : act_ext;
    assign new_delay = mtpd_pkg::bright_to_delay(item.brightness, cfg.off_threshold);

    for (genvar i = 0; i < N; i++)
    begin : g_ch
        logic active;
        logic hit;
        assign active = mtpd_pkg::CNT_W'(i) < drive_n;
        assign hit    = mtpd_pkg::CNT_W'(item.channel) == mtpd_pkg::CNT_W'(i);

        always_comb
        begin
            delay_next[i] = delay_reg[i];
            step_next[i]  = step_reg[i];
            armed_next[i] = armed_reg[i];
            gate_next[i]  = gate_reg[i];
            case (item.req_type)
                mtpd_pkg::REQ_SET:
                begin
                    if (hit)
                    begin
                        delay_next[i] = new_delay;
                    end
                end
                mtpd_pkg::REQ_ZERO:
                begin
                    step_next[i] = '0;
                    if (active)
                    begin
                        gate_next[i]  = 1'b0;
                        armed_next[i] = 1'b1;
                    end
                end
                mtpd_pkg::REQ_TICK:
                begin
                    if (active && armed_reg[i])
                    begin
                        if (step_reg[i] >= delay_reg[i])
                        begin
                            gate_next[i]  = 1'b1;
                            step_next[i]  = '0;
                            armed_next[i] = 1'b0;
                        end
                        else if (step_reg[i] < mtpd_pkg::STEP_MAX)
                        begin
                            step_next[i] = step_reg[i] + 1'b1;
                        end
                    end
                end
                default:
                begin
                    gate_next[i] = gate_reg[i];
                end
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                delay_reg[i] <= '0;
                step_reg[i]  <= '0;
                armed_reg[i] <= 1'b0;
                gate_reg[i]  <= 1'b0;
            end
            else if (en)
            begin
                delay_reg[i] <= delay_next[i];
                step_reg[i]  <= step_next[i];
                armed_reg[i] <= armed_next[i];
                gate_reg[i]  <= gate_next[i];
            end
        end
    end

    assign status.gate      = gate_reg;
    assign status.armed     = armed_reg;
    assign status.gate_next = gate_next;

endmodule

### hw/rtl/multichannel_triac_phase_dimmer.sv
// Phase-angle dimmer for CHANNELS triac gates. Each transfer on the input channel is a
// tick, a zero crossing or a set-brightness request, and yields exactly one result: the
// gate levels of all channels after that request. One request is taken every clock cycle
// while input stall is low. The edge that takes a request loads the input register; a later
// edge, once the result register is empty or its output is not stalled, runs the
// per-channel update into the result register and makes the result valid. Input stall is
// raised only while both the input register and the result register are full and the
// output is stalled. Configuration writes (active channel count, off threshold) are
// always accepted and should be issued only with no request in flight.
`include "multichannel_triac_phase_dimmer_assert.svh"

module multichannel_triac_phase_dimmer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [3:0]                    channel,
    input  logic [7:0]                    brightness,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mtpd_pkg::CHANNELS-1:0] gates,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [7:0]                    cfg_data
);

    mtpd_pkg::cfg_t    cfg;
    mtpd_pkg::status_t status;
    mtpd_pkg::item_t   item_reg;

    logic                          in_vld_reg;
    logic                          in_vld_next;
    logic                          out_vld_reg;
    logic                          out_vld_next;
    logic [mtpd_pkg::CHANNELS-1:0] gates_reg;
    logic                          out_free;
    logic                          advance;
    logic                          accept;

    mtpd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mtpd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .status (status)
    );

    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_free)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.req_type   <= req_type;
            item_reg.channel    <= channel;
            item_reg.brightness <= brightness;
        end
        if (advance)
        begin
            gates_reg <= status.gate_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign gates     = gates_reg;

    // a channel is armed only while its gate waits low for the firing point
    `MTPD_ASSERT_ALWAYS(a_armed_gate_low, (status.armed & status.gate) == '0)
    `MTPD_ASSERT_IMPLY(a_stall_cause, in_stall, out_valid && out_stall)
    `MTPD_ASSERT_IMPLY(a_result_source, $rose(out_valid), $past(in_vld_reg))

endmodule
